### hdl/rfs_pkg.sv
package rfs_pkg;

    // calc_mode codes
    localparam logic [2:0] MODE_N1      = 3'd0;
    localparam logic [2:0] MODE_N2      = 3'd1;
    localparam logic [2:0] MODE_ANG_INC = 3'd2;
    localparam logic [2:0] MODE_ANG_REF = 3'd3;
    localparam logic [2:0] MODE_CRIT    = 3'd4;
    localparam logic [2:0] MODE_RESET   = MODE_ANG_REF;

    // register index, taken from paddr[2]
    localparam logic REG_CALC_MODE = 1'b0;

    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic [15:0] INDEX_MAX      = 16'hFFFF;

    // Taylor divisors, innermost term first
    localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};
    localparam int          RECIP_SHIFT    = 35;

    // numerator and denominator widths of the quotient unit
    localparam int NUM_W = 47;
    localparam int DEN_W = 31;

    typedef struct packed {
        logic [15:0] idx;
        logic        sat;
        logic        derr;
        logic        kind;
        logic        neg;
    } rfs_res_t;

    typedef struct packed {
        logic kind;
        logic neg;
        logic den0;
    } rfs_div_tag_t;

endpackage

### hdl/rfs_sine.sv
module rfs_sine import rfs_pkg::*; #(
    parameter  int AFB = 8,
    parameter  int PW  = 1,
    localparam int AW  = $clog2((90 << AFB) + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [AW-1:0] in_deg,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [30:0]   out_sin,
    output logic [PW-1:0] out_pay
);

    localparam int PA = AW + 25;

    // stage A: degrees to Q30 radians
    logic [PA-1:0] prod_a;
    logic          a_vld_reg;
    logic [30:0]   a_x_reg;
    logic [PW-1:0] a_pay_reg;

    assign prod_a = PA'(in_deg) * PA'(DEG_TO_RAD_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_x_reg   <= prod_a[AFB+30:AFB];
            a_pay_reg <= in_pay;
        end
    end

    // stage B: x squared
    logic [61:0] sq_b;
    logic        h_vld_reg [6];
    logic [30:0] h_t_reg   [6];
    logic [30:0] h_x_reg   [6];
    logic [31:0] h_x2_reg  [6];
    logic [PW-1:0] h_pay_reg [6];

    assign sq_b = 62'(a_x_reg) * 62'(a_x_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_vld_reg[0] <= 1'b0;
        end else if (en) begin
            h_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_t_reg[0]   <= Q30_ONE;
            h_x_reg[0]   <= a_x_reg;
            h_x2_reg[0]  <= sq_b[61:30];
            h_pay_reg[0] <= a_pay_reg;
        end
    end

    // Horner steps: t = 1 - (x2*t)/d, three stages each
    for (genvar i = 0; i < 5; i++) begin : g_horner
        localparam logic [32:0] RECIP = 33'((64'd1 << RECIP_SHIFT) / 64'(HORNER_DIV[i]));
        localparam logic [6:0]  DIV   = 7'(HORNER_DIV[i]);

        logic [62:0]   p1;
        logic [65:0]   p2;
        logic [37:0]   p3;
        logic [31:0]   rem3;
        logic [30:0]   q3;
        logic          v1_reg, v2_reg;
        logic [31:0]   y1_reg, y2_reg;
        logic [30:0]   x1_reg, x2v_reg, qe2_reg;
        logic [31:0]   sq1_reg, sq2_reg;
        logic [PW-1:0] pay1_reg, pay2_reg;

        assign p1   = 63'(h_x2_reg[i]) * 63'(h_t_reg[i]);
        assign p2   = 66'(y1_reg) * 66'(RECIP);
        assign p3   = 38'(qe2_reg) * 38'(DIV);
        assign rem3 = y2_reg - p3[31:0];
        // reciprocal estimate is at most one low
        assign q3   = (rem3 >= 32'(DIV)) ? qe2_reg + 31'd1 : qe2_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v1_reg         <= 1'b0;
                v2_reg         <= 1'b0;
                h_vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                v1_reg         <= h_vld_reg[i];
                v2_reg         <= v1_reg;
                h_vld_reg[i+1] <= v2_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                y1_reg         <= p1[61:30];
                x1_reg         <= h_x_reg[i];
                sq1_reg        <= h_x2_reg[i];
                pay1_reg       <= h_pay_reg[i];
                y2_reg         <= y1_reg;
                qe2_reg        <= p2[RECIP_SHIFT+30:RECIP_SHIFT];
                x2v_reg        <= x1_reg;
                sq2_reg        <= sq1_reg;
                pay2_reg       <= pay1_reg;
                h_t_reg[i+1]   <= Q30_ONE - q3;
                h_x_reg[i+1]   <= x2v_reg;
                h_x2_reg[i+1]  <= sq2_reg;
                h_pay_reg[i+1] <= pay2_reg;
            end
        end
    end

    // final: x*t, clipped to one
    logic [61:0]   prod_f;
    logic          f_vld_reg;
    logic [30:0]   f_sin_reg;
    logic [PW-1:0] f_pay_reg;

    assign prod_f = 62'(h_x_reg[5]) * 62'(h_t_reg[5]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= h_vld_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_sin_reg <= (prod_f[61:30] > 32'(Q30_ONE)) ? Q30_ONE : prod_f[60:30];
            f_pay_reg <= h_pay_reg[5];
        end
    end

    assign out_valid = f_vld_reg;
    assign out_sin   = f_sin_reg;
    assign out_pay   = f_pay_reg;

endmodule

### hdl/rfs_div.sv
module rfs_div #(
    parameter int NW = 47,
    parameter int DW = 31,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    // restoring division, one quotient bit per stage, MSB first
    logic          vld_reg [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic [PW-1:0] pay_reg [NW];

    for (genvar j = 0; j < NW; j++) begin : g_stage
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] quo_in;
        logic [NW-1:0] num_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (j == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign den_in = in_den;
            assign quo_in = '0;
            assign num_in = in_num;
            assign pay_in = in_pay;
        end else begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign num_in = num_reg[j-1];
            assign pay_in = pay_reg[j-1];
        end

        assign trial = {rem_in, num_in[NW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= take ? diff[DW-1:0] : trial[DW-1:0];
                quo_reg[j] <= {quo_in[NW-2:0], take};
                num_reg[j] <= num_in << 1;
                den_reg[j] <= den_in;
                pay_reg[j] <= pay_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_pay   = pay_reg[NW-1];

endmodule

### hdl/refraction_solver_unit.sv
// Snell's law solver. Each input beat carries two indices (unsigned, 12 fraction bits at the
// default) and two angles (signed degrees, ANGLE_FRAC_BITS fraction bits); calc_mode picks
// the quantity solved: 0 incident index, 1 refracted index, 2 incidence angle, 3 refraction
// angle, 4 critical angle. Beats arriving under modes 5 to 7 are dropped with no result.
// The block takes one beat per clock while the output is not stalled, and has no state
// between beats. It is built from an 18-stage sine pipeline, a 47-stage restoring divider,
// and an arcsine done as S bisection steps of one sine pipeline plus a compare stage each,
// S = clog2(90*2^ANGLE_FRAC_BITS + 1). A stalled m_tready freezes the whole pipe. Write
// calc_mode only while the pipe is empty.
module refraction_solver_unit import rfs_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // n_incident, n_refracted, angle_incident, angle_refracted
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // result_value[16:0], zero pad
    output logic [2:0]  m_tuser    // result_kind, domain_error, saturated
);

    localparam int AFB        = ANGLE_FRAC_BITS;
    localparam int QUARTER    = 90 << AFB;
    localparam int HALF       = 180 << AFB;
    localparam int FULL       = 360 << AFB;
    localparam int AW         = $clog2(QUARTER + 1);
    localparam int AB         = AW + 1;
    localparam int STEPS      = $clog2(QUARTER + 1);
    localparam int OFF        = FULL * ((32768 + FULL - 1) / FULL);
    localparam int UW         = $clog2(32768 + OFF);
    localparam int UB         = UW + 1;
    localparam int FOLD_STEPS = $clog2((32768 + OFF) / FULL + 1);
    localparam int RW         = $bits(rfs_res_t);
    localparam int TW         = $bits(rfs_div_tag_t);
    localparam int APW        = 36;
    localparam int BPW        = 3 * AW + 31 + RW;

    // ---------------- register port ----------------
    logic [2:0] mode_reg;
    logic       cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CALC_MODE) ? {29'd0, mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (cfg_wr && paddr[2] == REG_CALC_MODE) begin
            mode_reg <= pwdata[2:0];
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic m_vld_reg;

    assign en       = !m_vld_reg || m_tready;
    assign s_tready = en;

    // reduce a raw angle to [0, 90 deg] plus the sign of its sine
    function automatic logic [AW:0] fold_angle(input logic [15:0] raw);
        logic [UB-1:0] u;
        logic          neg;
        neg = 1'b0;
        u   = UB'(32'(signed'(raw)) + OFF);
        for (int j = FOLD_STEPS - 1; j >= 0; j--) begin
            if (u >= UB'(FULL << j)) begin
                u = u - UB'(FULL << j);
            end
        end
        if (u >= UB'(HALF)) begin
            neg = 1'b1;
            u   = u - UB'(HALF);
        end
        if (u > UB'(QUARTER)) begin
            u = UB'(HALF) - u;
        end
        return {neg, AW'(u)};
    endfunction

    // ---------------- stage 0: capture and fold ----------------
    logic          s0_vld_reg;
    logic [15:0]   s0_n1_reg, s0_n2_reg;
    logic [2:0]    s0_mode_reg;
    logic [AW:0]   s0_f1_reg, s0_f2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg <= s_tvalid && (mode_reg <= MODE_CRIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_n1_reg   <= s_tdata[15:0];
            s0_n2_reg   <= s_tdata[31:16];
            s0_mode_reg <= mode_reg;
            s0_f1_reg   <= fold_angle(s_tdata[47:32]);
            s0_f2_reg   <= fold_angle(s_tdata[63:48]);
        end
    end

    // ---------------- sines of both angles ----------------
    logic           sa_vld, sb_vld;
    logic [30:0]    sa_sin, sb_sin;
    logic [APW-1:0] sa_pay;
    logic [0:0]     sb_pay;

    rfs_sine #(.AFB(AFB), .PW(APW)) u_sine_inc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_vld_reg),
        .in_deg    (s0_f1_reg[AW-1:0]),
        .in_pay    ({s0_n1_reg, s0_n2_reg, s0_mode_reg, s0_f1_reg[AW]}),
        .out_valid (sa_vld),
        .out_sin   (sa_sin),
        .out_pay   (sa_pay)
    );

    rfs_sine #(.AFB(AFB), .PW(1)) u_sine_ref (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s0_vld_reg),
        .in_deg    (s0_f2_reg[AW-1:0]),
        .in_pay    (s0_f2_reg[AW]),
        .out_valid (sb_vld),
        .out_sin   (sb_sin),
        .out_pay   (sb_pay)
    );

    // ---------------- numerator / denominator ----------------
    logic [15:0]      sa_n1, sa_n2;
    logic [2:0]       sa_mode;
    logic             sa_neg;
    logic             sel_ref;
    logic [15:0]      mul_n;
    logic [30:0]      mul_s;
    logic [NUM_W-1:0] mul_p;
    logic [NUM_W-1:0] num_c;
    logic [DEN_W-1:0] den_c;
    rfs_div_tag_t     tag_c;

    assign {sa_n1, sa_n2, sa_mode, sa_neg} = sa_pay;
    assign sel_ref = (sa_mode == MODE_N1) || (sa_mode == MODE_ANG_INC);
    assign mul_n   = sel_ref ? sa_n2 : sa_n1;
    assign mul_s   = sel_ref ? sb_sin : sa_sin;
    assign mul_p   = NUM_W'(mul_n) * NUM_W'(mul_s);
    assign num_c   = (sa_mode == MODE_CRIT) ? NUM_W'({sa_n2, 30'd0}) : mul_p;

    always_comb begin
        tag_c.kind = (sa_mode >= MODE_ANG_INC);
        tag_c.neg  = 1'b0;
        case (sa_mode)
            MODE_N1:      den_c = sa_sin;
            MODE_N2:      den_c = sb_sin;
            MODE_ANG_INC: begin
                den_c     = DEN_W'(sa_n1);
                tag_c.neg = sb_pay[0] && (sb_sin != '0);
            end
            MODE_ANG_REF: begin
                den_c     = DEN_W'(sa_n2);
                tag_c.neg = sa_neg && (sa_sin != '0);
            end
            default:      den_c = DEN_W'(sa_n1);
        endcase
        tag_c.den0 = (den_c == '0);
    end

    logic             mu_vld_reg;
    logic [NUM_W-1:0] mu_num_reg;
    logic [DEN_W-1:0] mu_den_reg;
    rfs_div_tag_t     mu_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_vld_reg <= 1'b0;
        end else if (en) begin
            mu_vld_reg <= sa_vld && sb_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_num_reg <= num_c;
            mu_den_reg <= den_c;
            mu_tag_reg <= tag_c;
        end
    end

    // ---------------- quotient ----------------
    logic             dv_vld;
    logic [NUM_W-1:0] dv_quo;
    logic [TW-1:0]    dv_pay;
    rfs_div_tag_t     dv_tag;

    rfs_div #(.NW(NUM_W), .DW(DEN_W), .PW(TW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mu_vld_reg),
        .in_num    (mu_num_reg),
        .in_den    (mu_den_reg),
        .in_pay    (mu_tag_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    assign dv_tag = rfs_div_tag_t'(dv_pay);

    // ---------------- arcsine bisection ----------------
    logic          st_vld_reg [STEPS+1];
    logic [AW-1:0] st_lo_reg  [STEPS+1];
    logic [AW-1:0] st_hi_reg  [STEPS+1];
    logic [30:0]   st_v_reg   [STEPS+1];
    rfs_res_t      st_res_reg [STEPS+1];

    logic          q_big;
    logic          q_over;
    rfs_res_t      res_c;

    assign q_big  = |dv_quo[NUM_W-1:16];
    assign q_over = dv_quo > NUM_W'(Q30_ONE);

    always_comb begin
        res_c.kind = dv_tag.kind;
        res_c.neg  = dv_tag.neg;
        if (!dv_tag.kind) begin
            res_c.derr = dv_tag.den0;
            res_c.sat  = !dv_tag.den0 && q_big;
            res_c.idx  = dv_tag.den0 ? 16'd0 : (q_big ? INDEX_MAX : dv_quo[15:0]);
        end else begin
            res_c.derr = dv_tag.den0 || q_over;
            res_c.sat  = 1'b0;
            res_c.idx  = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg[0] <= 1'b0;
        end else if (en) begin
            st_vld_reg[0] <= dv_vld;
        end
    end

    // index results and errors ride through with an empty search range
    always_ff @(posedge aclk) begin
        if (en) begin
            st_lo_reg[0]  <= '0;
            st_hi_reg[0]  <= (res_c.kind && !res_c.derr) ? AW'(QUARTER) : '0;
            st_v_reg[0]   <= res_c.derr ? 31'd0 : dv_quo[30:0];
            st_res_reg[0] <= res_c;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_bisect
        logic [AB-1:0]  span;
        logic [AW-1:0]  mid;
        logic           b_vld;
        logic [30:0]    b_sin;
        logic [BPW-1:0] b_pay;
        logic [AW-1:0]  b_lo, b_hi, b_mid;
        logic [30:0]    b_v;
        logic [RW-1:0]  b_res;
        logic           open_c;
        logic           fits_c;

        assign span = AB'(st_hi_reg[k]) - AB'(st_lo_reg[k]) + AB'(1);
        assign mid  = st_lo_reg[k] + AW'(span >> 1);

        rfs_sine #(.AFB(AFB), .PW(BPW)) u_sine (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (st_vld_reg[k]),
            .in_deg    (mid),
            .in_pay    ({st_lo_reg[k], st_hi_reg[k], mid, st_v_reg[k], st_res_reg[k]}),
            .out_valid (b_vld),
            .out_sin   (b_sin),
            .out_pay   (b_pay)
        );

        assign {b_lo, b_hi, b_mid, b_v, b_res} = b_pay;
        assign open_c = b_lo < b_hi;
        assign fits_c = b_sin <= b_v;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                st_vld_reg[k+1] <= b_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_lo_reg[k+1]  <= (open_c && fits_c) ? b_mid : b_lo;
                st_hi_reg[k+1]  <= (open_c && !fits_c) ? b_mid - AW'(1) : b_hi;
                st_v_reg[k+1]   <= b_v;
                st_res_reg[k+1] <= rfs_res_t'(b_res);
            end
        end
    end

    // ---------------- output register ----------------
    rfs_res_t    fin_res;
    logic [16:0] ang_c;
    logic [16:0] val_c;
    logic [16:0] m_value_reg;
    logic [2:0]  m_user_reg;

    assign fin_res = st_res_reg[STEPS];
    assign ang_c   = 17'(st_lo_reg[STEPS]);
    assign val_c   = fin_res.kind ? (fin_res.neg ? -ang_c : ang_c) : {1'b0, fin_res.idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= st_vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_value_reg <= val_c;
            m_user_reg  <= {fin_res.sat, fin_res.derr, fin_res.kind};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {7'd0, m_value_reg};
    assign m_tuser  = m_user_reg;

    // ---------------- checks ----------------
    // the search must have closed by the last step
    a_bisect_done: assert property (@(posedge aclk) disable iff (!aresetn)
        st_vld_reg[STEPS] |-> st_lo_reg[STEPS] == st_hi_reg[STEPS])
        else $error("arcsine search not converged");

    a_sat_index_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[2] && (m_tuser[0] || m_tuser[1])))
        else $error("saturation flagged on angle or error result");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[16:0] == 17'd0)
        else $error("error result carries a value");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(st_vld_reg[STEPS]) && $stable(mu_vld_reg))
        else $error("pipeline moved during stall");

endmodule

### tb/tb_refraction_solver_unit.sv
module tb_refraction_solver_unit;
    import rfs_pkg::*;

    localparam int AFB      = 8;
    localparam int LATENCY  = 69 + 19 * $clog2(90 * (2 ** AFB) + 1);
    localparam int N_RANDOM = 1250;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint Q1 = 64'd1 << 30;

    typedef struct packed {
        logic [16:0] value;
        logic        kind;
        logic        derr;
        logic        sat;
    } solution_t;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] n1;
        logic [15:0] n2;
        logic [15:0] a1;
        logic [15:0] a2;
        logic        typed;
        solution_t   sol;
    } vector_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // n_incident, n_refracted, angle_incident, angle_refracted
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // result_value[16:0], zero pad
    logic [2:0]  m_tuser;   // result_kind, domain_error, saturated

    solution_t   pending_solutions[$];
    logic [2:0]  mode_shadow;
    int          error_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    refraction_solver_unit #(.ANGLE_FRAC_BITS(AFB)) u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint sine_quad(longint deg);
        longint divs[5];
        longint x, x2, t;
        divs = '{110, 72, 42, 20, 6};
        x  = (deg * 18740330) >>> AFB;
        x2 = (x * x) >>> 30;
        t  = Q1;
        for (int i = 0; i < 5; i++)
            t = Q1 - ((x2 * t) >>> 30) / divs[i];
        t = (x * t) >>> 30;
        return (t > Q1) ? Q1 : t;
    endfunction

    function automatic longint signed_sine(logic [15:0] raw);
        longint a, r;
        longint full, half, quarter;
        logic neg;
        full = 360 << AFB;
        half = 180 << AFB;
        quarter = 90 << AFB;
        a = longint'($signed(raw));
        neg = 1'b0;
        r = a % full;
        if (r < 0) r += full;
        if (r >= half) begin
            neg = 1'b1;
            r -= half;
        end
        if (r > quarter) r = half - r;
        r = sine_quad(r);
        return neg ? -r : r;
    endfunction

    function automatic longint arcsine_code(longint v);
        longint lo, hi, mid;
        lo = 0;
        hi = 90 << AFB;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (sine_quad(mid) <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic longint magnitude(longint s);
        return (s < 0) ? -s : s;
    endfunction

    // returns 0 when the mode produces no beat
    function automatic bit solve_snell(logic [2:0] mode, logic [15:0] n1, logic [15:0] n2,
                                       logic [15:0] a1, logic [15:0] a2,
                                       output solution_t sol);
        longint s1, s2, num, den, q, value;
        logic neg;
        s1 = signed_sine(a1);
        s2 = signed_sine(a2);
        value = 0;
        sol = '0;
        neg = 1'b0;
        if (mode == MODE_N1 || mode == MODE_N2) begin
            num = (mode == MODE_N1) ? n2 * magnitude(s2) : n1 * magnitude(s1);
            den = (mode == MODE_N1) ? magnitude(s1) : magnitude(s2);
            if (den == 0) begin
                sol.derr = 1'b1;
            end else begin
                q = num / den;
                if (q > 65535) begin
                    q = 65535;
                    sol.sat = 1'b1;
                end
                value = q;
            end
        end else if (mode == MODE_ANG_INC || mode == MODE_ANG_REF || mode == MODE_CRIT) begin
            sol.kind = 1'b1;
            if (mode == MODE_ANG_INC) begin
                num = n2 * magnitude(s2);
                den = n1;
                neg = s2 < 0;
            end else if (mode == MODE_ANG_REF) begin
                num = n1 * magnitude(s1);
                den = n2;
                neg = s1 < 0;
            end else begin
                num = longint'(n2) << 30;
                den = n1;
            end
            if (den == 0 || num / den > Q1) begin
                sol.derr = 1'b1;
            end else begin
                value = arcsine_code(num / den);
                if (neg) value = -value;
            end
        end else begin
            return 1'b0;
        end
        sol.value = value[16:0];
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // result checker with random stall
    always @(posedge aclk) begin
        solution_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_solutions.size() == 0) begin
                    report_mismatch("unexpected beat", 32'(m_tdata), 32'd0);
                end else begin
                    want = pending_solutions.pop_front();
                    if (m_tdata[16:0] != want.value)
                        report_mismatch("result_value", 32'(m_tdata[16:0]), 32'(want.value));
                    if (m_tdata[23:17] != '0)
                        report_mismatch("tdata pad", 32'(m_tdata[23:17]), 32'd0);
                    if (m_tuser[0] != want.kind)
                        report_mismatch("result_kind", 32'(m_tuser[0]), 32'(want.kind));
                    if (m_tuser[1] != want.derr)
                        report_mismatch("domain_error", 32'(m_tuser[1]), 32'(want.derr));
                    if (m_tuser[2] != want.sat)
                        report_mismatch("saturated", 32'(m_tuser[2]), 32'(want.sat));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_mode(logic [2:0] mode);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CALC_MODE, 2'b00};
        pwdata  <= {29'd0, mode};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_shadow = mode;
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (pending_solutions.size() != 0) @(posedge aclk);
        // dropped beats may still be in flight
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    // leaves s_tvalid high after the accepting edge; the next beat or drain_pipe drops it
    task automatic send_beat(logic [15:0] n1, logic [15:0] n2, logic [15:0] a1,
                             logic [15:0] a2, logic typed, solution_t typed_sol);
        solution_t sol;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a2, a1, n2, n1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (solve_snell(mode_shadow, n1, n2, a1, a2, sol)) begin
            if (typed && sol != typed_sol)
                report_mismatch("predictor vs table", 32'(sol), 32'(typed_sol));
            pending_solutions.push_back(typed ? typed_sol : sol);
        end
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(46080)) - 23040);
            1: return 16'($signed($urandom_range(1000)) - 500);
            2: return 16'($urandom);
            default: return ($urandom_range(1) ? 16'd23040 : 16'(-23040));
        endcase
    endfunction

    function automatic logic [15:0] random_index();
        case ($urandom_range(3))
            0: return 16'($urandom_range(4096, 12288));
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(65530, 65535));
        endcase
    endfunction

    vector_t directed[$];

    function automatic vector_t row(logic [2:0] m, logic [15:0] n1, logic [15:0] n2,
                                    logic [15:0] a1, logic [15:0] a2, logic typed,
                                    solution_t sol);
        vector_t v;
        v.mode = m; v.n1 = n1; v.n2 = n2; v.a1 = a1; v.a2 = a2;
        v.typed = typed; v.sol = sol;
        return v;
    endfunction

    initial begin
        logic [2:0] cur_mode;
        logic [2:0] mode_plan[5];
        int phase;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        error_count = 0; cycle_count = 0;
        send_idle_pct = 21; recv_idle_pct = 45;
        mode_shadow = MODE_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // mode from reset: refraction angle, both sines zero
        directed.push_back(row(MODE_ANG_REF, 16'h1000, 16'h1000, 16'd0, 16'd0, 1,
                               '{17'd0, 1'b1, 1'b0, 1'b0}));
        // zero index divisor
        directed.push_back(row(MODE_ANG_REF, 16'h1000, 16'd0, 16'd7680, 16'd0, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(MODE_ANG_REF, 16'h2000, 16'h1000, 16'd23040, 16'd0, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(MODE_ANG_REF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 0, '0));
        directed.push_back(row(MODE_ANG_REF, 16'h1000, 16'h1800, 16'(-23040), 16'd0, 0, '0));
        directed.push_back(row(MODE_N1, 16'h1000, 16'h1000, 16'd0, 16'd7680, 1,
                               '{17'd0, 1'b0, 1'b1, 1'b0}));
        directed.push_back(row(MODE_N1, 16'h0, 16'hFFFF, 16'd10, 16'd23040, 1,
                               '{17'h0FFFF, 1'b0, 1'b0, 1'b1}));
        directed.push_back(row(MODE_N1, 16'h0, 16'h1000, 16'(-7680), 16'd7680, 0, '0));
        directed.push_back(row(MODE_N2, 16'h1000, 16'h1000, 16'd7680, 16'd0, 1,
                               '{17'd0, 1'b0, 1'b1, 1'b0}));
        directed.push_back(row(MODE_N2, 16'hFFFF, 16'h0, 16'd23040, 16'd1, 1,
                               '{17'h0FFFF, 1'b0, 1'b0, 1'b1}));
        directed.push_back(row(MODE_N2, 16'h1800, 16'h0, 16'd7680, 16'(-5000), 0, '0));
        directed.push_back(row(MODE_ANG_INC, 16'd0, 16'h1000, 16'd0, 16'd7680, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(MODE_ANG_INC, 16'h1800, 16'h1000, 16'd0, 16'(-11520), 0, '0));
        directed.push_back(row(MODE_ANG_INC, 16'h1000, 16'hFFFF, 16'd0, 16'd23040, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(MODE_CRIT, 16'd0, 16'h1000, 16'd0, 16'd0, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(MODE_CRIT, 16'h1000, 16'h1000, 16'd0, 16'd0, 1,
                               '{17'd23040, 1'b1, 1'b0, 1'b0}));
        directed.push_back(row(MODE_CRIT, 16'h1800, 16'h1000, 16'hFFFF, 16'h8000, 0, '0));
        directed.push_back(row(MODE_CRIT, 16'h1000, 16'h1001, 16'd0, 16'd0, 1,
                               '{17'd0, 1'b1, 1'b1, 1'b0}));
        directed.push_back(row(3'd5, 16'h1000, 16'h1000, 16'd0, 16'd0, 0, '0));
        directed.push_back(row(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0));

        cur_mode = MODE_RESET;
        foreach (directed[i]) begin
            if (directed[i].mode != cur_mode) begin
                drain_pipe();
                write_mode(directed[i].mode);
                cur_mode = directed[i].mode;
            end
            send_beat(directed[i].n1, directed[i].n2, directed[i].a1, directed[i].a2,
                      directed[i].typed, directed[i].sol);
        end

        // random part: three idling phases, every mode in each
        mode_plan = '{MODE_N1, MODE_N2, MODE_ANG_INC, MODE_ANG_REF, MODE_CRIT};
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 21 : 0;
            for (int m = 0; m < 6; m++) begin
                drain_pipe();
                write_mode(m == 5 ? 3'($urandom_range(5, 7)) : mode_plan[m]);
                for (int k = 0; k < (m == 5 ? 10 : N_RANDOM / 15); k++)
                    send_beat(random_index(), random_index(), random_angle(),
                              random_angle(), 1'b0, '0);
            end
        end

        drain_pipe();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rfs_pkg.sv
hdl/rfs_sine.sv
hdl/rfs_div.sv
hdl/refraction_solver_unit.sv
tb/tb_refraction_solver_unit.sv
